// File: sv/sm4_pkg.sv
// Shared types, constants and round functions for the SM4 CBC block.
// No dependencies; used by the front, back, top level and testbench.
`default_nettype none
package sm4_pkg;

    localparam int unsigned ROUNDS = 32;

    localparam logic [2:0] OP_ENC       = 3'd0;
    localparam logic [2:0] OP_DEC       = 3'd1;
    localparam logic [2:0] OP_CLR_ENC   = 3'd2;
    localparam logic [2:0] OP_CLR_DEC   = 3'd3;
    localparam logic [2:0] OP_CLR_BOTH  = 3'd4;

    localparam logic [1:0] CFG_KEY0 = 2'd0;
    localparam logic [1:0] CFG_KEY1 = 2'd1;
    localparam logic [1:0] CFG_KEY2 = 2'd2;
    localparam logic [1:0] CFG_KEY3 = 2'd3;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    typedef logic [$clog2(ROUNDS)-1:0] t_rnd;

    // Command handed from the front queue to the back engine.
    typedef struct packed {
        logic        valid;
        logic [2:0]  op;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_cmd;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] tau(input logic [31:0] t);
        return {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
    endfunction

    function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned r);
        return (v << r) | (v >> (32 - r));
    endfunction

    // Linear transform of the data rounds.
    function automatic logic [31:0] lin_d(input logic [31:0] t);
        return t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
    endfunction

    // Linear transform of the key schedule.
    function automatic logic [31:0] lin_k(input logic [31:0] t);
        return t ^ rol(t, 13) ^ rol(t, 23);
    endfunction

    // CK word: byte j of word i is (4i+j)*7 modulo 256.
    function automatic logic [31:0] ck_word(input t_rnd i);
        logic [31:0] w;
        logic [7:0]  b;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            b = 8'({i, 2'(j)} * 7);
            w = {w[23:0], b};
        end
        return w;
    endfunction

endpackage
`default_nettype wire

// File: sv/sm4_in_if.sv
// Input channel carrying one opcode and one 128-bit block per transfer.
// No dependencies.
`default_nettype none
interface sm4_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [63:0] data_hi;
    logic [63:0] data_lo;

    modport source (output valid, output opcode, output data_hi, output data_lo, input ready);
    modport sink   (input valid, input opcode, input data_hi, input data_lo, output ready);
endinterface
`default_nettype wire

// File: sv/sm4_out_if.sv
// Output channel carrying one 128-bit result block per transfer.
// No dependencies.
`default_nettype none
interface sm4_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_out_hi;
    logic [63:0] data_out_lo;

    modport source (output valid, output data_out_hi, output data_out_lo, input ready);
    modport sink   (input valid, input data_out_hi, input data_out_lo, output ready);
endinterface
`default_nettype wire

// File: sv/sm4_front.sv
// Front end: accepts input transfers, drops unused opcodes and queues the rest.
// Depends on sm4_pkg and sm4_in_if.
`default_nettype none
module sm4_front
    import sm4_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sm4_in_if.sink    i_blk,
    input  wire logic i_pop,
    output t_cmd      o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    logic       w_known;

    assign w_known = (i_blk.opcode == OP_ENC) || (i_blk.opcode == OP_DEC) ||
                     (i_blk.opcode == OP_CLR_ENC) || (i_blk.opcode == OP_CLR_DEC) ||
                     (i_blk.opcode == OP_CLR_BOTH);

    assign i_blk.ready = (r_cnt != 2'd2);
    assign w_push      = i_blk.valid && i_blk.ready && w_known;
    assign w_pop       = i_pop && (r_cnt != 2'd0);

    always_comb begin
        o_cmd       = r_q[r_rp];
        o_cmd.valid = (r_cnt != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{valid: 1'b1, op: i_blk.opcode, hi: i_blk.data_hi,
                           lo: i_blk.data_lo};
        end
    end

endmodule
`default_nettype wire

// File: sv/sm4_back.sv
// Back end: key schedule, 32 SM4 rounds, CBC chains and the output register.
// Depends on sm4_pkg and sm4_out_if.
`default_nettype none
module sm4_back
    import sm4_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic [127:0] i_key,
    input  wire t_cmd         i_cmd,
    output logic              o_pop,
    sm4_out_if.source         o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EPRE = 3'd1;
    localparam logic [2:0] S_ERUN = 3'd2;
    localparam logic [2:0] S_DKEY = 3'd3;
    localparam logic [2:0] S_DRUN = 3'd4;

    logic [2:0]   r_state, n_state;
    t_rnd         r_cnt;
    logic [31:0]  r_w [4];
    logic [31:0]  r_x [4];
    logic [31:0]  r_rk;
    logic [127:0] r_aux;
    logic [127:0] r_enc;
    logic [127:0] r_dec;
    logic         r_out_valid;
    logic [127:0] r_out;

    t_rnd         w_ck_idx;
    logic [31:0]  w_kfwd;
    logic [31:0]  w_kback;
    logic [31:0]  w_rk;
    logic [31:0]  w_t;
    logic [127:0] w_res;
    logic         w_last;
    logic         w_is_clr;

    assign w_is_clr = (i_cmd.op == OP_CLR_ENC) || (i_cmd.op == OP_CLR_DEC) ||
                      (i_cmd.op == OP_CLR_BOTH);
    assign o_pop    = (r_state == S_IDLE) && i_cmd.valid && (w_is_clr || !r_out_valid);

    always_comb begin
        case (r_state)
            S_EPRE:  w_ck_idx = '0;
            S_ERUN:  w_ck_idx = r_cnt + t_rnd'(1);
            default: w_ck_idx = r_cnt;
        endcase
    end

    assign w_kfwd  = r_w[0] ^ lin_k(tau(r_w[1] ^ r_w[2] ^ r_w[3] ^ ck_word(w_ck_idx)));
    assign w_kback = r_w[3] ^ lin_k(tau(r_w[0] ^ r_w[1] ^ r_w[2] ^ ck_word(~r_cnt)));
    assign w_rk    = (r_state == S_DRUN) ? r_w[3] : r_rk;
    assign w_t     = r_x[0] ^ lin_d(tau(r_x[1] ^ r_x[2] ^ r_x[3] ^ w_rk));
    assign w_res   = {w_t, r_x[3], r_x[2], r_x[1]};
    assign w_last  = (r_cnt == t_rnd'(ROUNDS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_pop && (i_cmd.op == OP_ENC)) begin
                    n_state = S_EPRE;
                end else if (o_pop && (i_cmd.op == OP_DEC)) begin
                    n_state = S_DKEY;
                end
            end
            S_EPRE: n_state = S_ERUN;
            S_ERUN: begin
                if (w_last) begin
                    n_state = S_IDLE;
                end
            end
            S_DKEY: begin
                if (w_last) begin
                    n_state = S_DRUN;
                end
            end
            S_DRUN: begin
                if (w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_enc       <= '0;
            r_dec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (o_pop) begin
                        if ((i_cmd.op == OP_CLR_ENC) || (i_cmd.op == OP_CLR_BOTH)) begin
                            r_enc <= '0;
                        end
                        if ((i_cmd.op == OP_CLR_DEC) || (i_cmd.op == OP_CLR_BOTH)) begin
                            r_dec <= '0;
                        end
                        if (i_cmd.op == OP_DEC) begin
                            r_dec <= {i_cmd.hi, i_cmd.lo};
                        end
                    end
                end
                S_EPRE: r_cnt <= '0;
                S_ERUN: begin
                    r_cnt <= r_cnt + t_rnd'(1);
                    if (w_last) begin
                        r_enc       <= w_res;
                        r_out       <= w_res;
                        r_out_valid <= 1'b1;
                    end
                end
                S_DKEY: r_cnt <= r_cnt + t_rnd'(1);
                S_DRUN: begin
                    r_cnt <= r_cnt + t_rnd'(1);
                    if (w_last) begin
                        r_out       <= w_res ^ r_aux;
                        r_out_valid <= 1'b1;
                    end
                end
                default: r_cnt <= '0;
            endcase
        end
    end

    // Datapath registers: key window, block words and the saved chain value.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_w[0] <= FK0 ^ i_key[127:96];
                r_w[1] <= FK1 ^ i_key[95:64];
                r_w[2] <= FK2 ^ i_key[63:32];
                r_w[3] <= FK3 ^ i_key[31:0];
                if (i_cmd.op == OP_ENC) begin
                    {r_x[0], r_x[1], r_x[2], r_x[3]} <= {i_cmd.hi, i_cmd.lo} ^ r_enc;
                end else begin
                    {r_x[0], r_x[1], r_x[2], r_x[3]} <= {i_cmd.hi, i_cmd.lo};
                end
                r_aux <= r_dec;
            end
            S_EPRE, S_ERUN, S_DKEY: begin
                r_w[0] <= r_w[1];
                r_w[1] <= r_w[2];
                r_w[2] <= r_w[3];
                r_w[3] <= w_kfwd;
                r_rk   <= w_kfwd;
                if (r_state == S_ERUN) begin
                    r_x[0] <= r_x[1];
                    r_x[1] <= r_x[2];
                    r_x[2] <= r_x[3];
                    r_x[3] <= w_t;
                end
            end
            S_DRUN: begin
                r_w[0] <= w_kback;
                r_w[1] <= r_w[0];
                r_w[2] <= r_w[1];
                r_w[3] <= r_w[2];
                r_x[0] <= r_x[1];
                r_x[1] <= r_x[2];
                r_x[2] <= r_x[3];
                r_x[3] <= w_t;
            end
            default: r_rk <= r_rk;
        endcase
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.data_out_hi = r_out[127:64];
    assign o_res.data_out_lo = r_out[63:0];

endmodule
`default_nettype wire

// File: sv/sm4_cbc_block_cipher.sv
// SM4-128 in CBC mode: key registers, command queue and round engine.
// Encrypt: a key preload step, then 32 rounds from queue pop to result; decrypt: 32 key steps, then 32 rounds.
// The engine works on one block at a time and starts the next only once the last result is taken; a clear pops at once.
// Up to two commands queue ahead of the engine, so input transfers continue while it runs.
// Reset (synchronous, active low) zeroes the keys and both chains and empties the queue.
// Depends on sm4_pkg, sm4_in_if, sm4_out_if, sm4_front and sm4_back.
`default_nettype none
module sm4_cbc_block_cipher
    import sm4_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sm4_in_if.sink           i_blk,
    sm4_out_if.source        o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    // The key words are held here and read by the engine when a block starts, so a
    // key change takes effect from the next block and never disturbs the chains.
    logic [31:0] r_key [4];
    t_cmd        w_cmd;
    logic        w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= '0;
            r_key[1] <= '0;
            r_key[2] <= '0;
            r_key[3] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY0: r_key[0] <= i_cfg_data;
                CFG_KEY1: r_key[1] <= i_cfg_data;
                CFG_KEY2: r_key[2] <= i_cfg_data;
                CFG_KEY3: r_key[3] <= i_cfg_data;
                default:  r_key[0] <= r_key[0];
            endcase
        end
    end

    // The front end takes transfers while its queue has room, discards the unused opcodes and
    // queues the rest; the idle back end pops a clear at once, a block once no result waits.
    sm4_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk   (i_blk),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd)
    );

    // Decryption runs the key schedule forward once and then steps it backwards,
    // producing the round keys in reverse order without storing them.
    sm4_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_cmd   (w_cmd),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the SM4 CBC block cipher: a behavioural SM4 predictor
// checks every result transfer. Depends on sm4_pkg, sm4_in_if, sm4_out_if and the RTL.
`default_nettype none
module testbench
    import sm4_pkg::*;
();

    localparam int DRAIN_CYCLES = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    sm4_in_if  blk_if();
    sm4_out_if res_if();

    sm4_cbc_block_cipher u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_blk(blk_if.sink), .o_res(res_if.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // The predictor keeps its own copy of the key registers and of both chains.
    logic [31:0] key_reg [4];
    logic [63:0] enc_iv_hi, enc_iv_lo, dec_iv_hi, dec_iv_lo;
    logic [127:0] expected_blocks [$];
    int error_count = 0;
    bit stall_enable = 1'b1;

    // The standard SM4 byte substitution table, kept apart from the design package.
    logic [7:0] sub_table [256];
    initial begin
        sub_table = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
        };
    end

    function automatic logic [31:0] substitute_word(input logic [31:0] w);
        return {sub_table[w[31:24]], sub_table[w[23:16]], sub_table[w[15:8]], sub_table[w[7:0]]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] w, input int n);
        logic [63:0] d;
        d = {w, w} >> (32 - n);
        return d[31:0];
    endfunction

    // Runs the key schedule and the 32 rounds on one block; reverse selects decryption.
    function automatic logic [127:0] sm4_cipher(input logic [127:0] blk, input bit reverse);
        logic [31:0] k [4];
        logic [31:0] x [4];
        logic [31:0] rk [32];
        logic [31:0] t, ck;
        k[0] = 32'ha3b1bac6 ^ key_reg[0];
        k[1] = 32'h56aa3350 ^ key_reg[1];
        k[2] = 32'h677d9197 ^ key_reg[2];
        k[3] = 32'hb27022dc ^ key_reg[3];
        for (int i = 0; i < 32; i++) begin
            for (int j = 0; j < 4; j++) ck[31-8*j -: 8] = 8'(((4*i + j) * 7) & 8'hff);
            t = substitute_word(k[1] ^ k[2] ^ k[3] ^ ck);
            t = k[0] ^ t ^ rotl(t, 13) ^ rotl(t, 23);
            rk[i] = t;
            k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = t;
        end
        x[0] = blk[127:96]; x[1] = blk[95:64]; x[2] = blk[63:32]; x[3] = blk[31:0];
        for (int i = 0; i < 32; i++) begin
            t = substitute_word(x[1] ^ x[2] ^ x[3] ^ (reverse ? rk[31-i] : rk[i]));
            t = x[0] ^ t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
            x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = t;
        end
        return {x[3], x[2], x[1], x[0]};
    endfunction

    // Updates the chains and queues the block that the engine should return, if any.
    task automatic predict_block(input logic [2:0] op, input logic [63:0] hi,
                                 input logic [63:0] lo);
        logic [127:0] r;
        case (op)
            OP_ENC: begin
                r = sm4_cipher({hi ^ enc_iv_hi, lo ^ enc_iv_lo}, 1'b0);
                {enc_iv_hi, enc_iv_lo} = r;
                expected_blocks.push_back(r);
            end
            OP_DEC: begin
                r = sm4_cipher({hi, lo}, 1'b1) ^ {dec_iv_hi, dec_iv_lo};
                dec_iv_hi = hi; dec_iv_lo = lo;
                expected_blocks.push_back(r);
            end
            OP_CLR_ENC: begin
                enc_iv_hi = '0; enc_iv_lo = '0;
            end
            OP_CLR_DEC: begin
                dec_iv_hi = '0; dec_iv_lo = '0;
            end
            OP_CLR_BOTH: begin
                enc_iv_hi = '0; enc_iv_lo = '0; dec_iv_hi = '0; dec_iv_lo = '0;
            end
            default: begin
            end
        endcase
    endtask

    // Drives one block; the sender works in bursts separated by random gaps. Valid stays
    // high after a transfer and drops only for a gap or when the sender goes quiet.
    int burst_left = 0;
    task automatic send_block(input logic [2:0] op, input logic [63:0] hi, input logic [63:0] lo);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
            if (gap != 0) begin
                blk_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        blk_if.valid <= 1'b1;
        blk_if.opcode <= op;
        blk_if.data_hi <= hi;
        blk_if.data_lo <= lo;
        @(posedge i_clk);
        while (!blk_if.ready) @(posedge i_clk);
        predict_block(op, hi, lo);
    endtask

    // Stops sending, then waits until every result is back and lets any queued clear drain,
    // so the block is idle.
    task automatic wait_idle();
        int guard;
        guard = 0;
        blk_if.valid <= 1'b0;
        while (expected_blocks.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_key(input logic [1:0] idx, input logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        key_reg[idx] = value;
    endtask

    task automatic load_key(input logic [127:0] key);
        wait_idle();
        write_key(CFG_KEY0, key[127:96]);
        write_key(CFG_KEY1, key[95:64]);
        write_key(CFG_KEY2, key[63:32]);
        write_key(CFG_KEY3, key[31:0]);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Known-answer check from the standard, then field extremes and every opcode.
    task automatic test_directed();
        load_key(128'h0123456789abcdeffedcba9876543210);
        send_block(OP_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(OP_CLR_ENC, '1, '1);
        send_block(OP_DEC, 64'h681edf34d206965e, 64'h86b3e94f536e4246);
        send_block(OP_ENC, '0, '0);
        send_block(OP_ENC, '1, '1);
        send_block(OP_DEC, '1, '0);
        send_block(OP_DEC, '0, '1);
        send_block(OP_CLR_DEC, '0, '0);
        send_block(OP_DEC, 64'h8000000000000000, 64'h1);
        send_block(3'd5, '1, '1);
        send_block(3'd6, '0, '0);
        send_block(3'd7, rand64(), rand64());
        send_block(OP_CLR_BOTH, rand64(), rand64());
        send_block(OP_ENC, rand64(), rand64());
        send_block(OP_DEC, rand64(), rand64());
        // A key change keeps both chains.
        load_key('1);
        send_block(OP_ENC, rand64(), rand64());
        send_block(OP_DEC, rand64(), rand64());
        load_key('0);
        send_block(OP_ENC, '0, '0);
        send_block(OP_DEC, '0, '0);
    endtask

    // Mostly chained encrypt and decrypt runs with random data, with clears and unused
    // opcodes as noise, across several random keys.
    task automatic test_random();
        int pick;
        logic [2:0] op;
        for (int phase = 0; phase < 8; phase++) begin
            load_key({$urandom, $urandom, $urandom, $urandom});
            for (int n = 0; n < 100; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 44) op = OP_ENC;
                else if (pick < 88) op = OP_DEC;
                else if (pick < 91) op = OP_CLR_ENC;
                else if (pick < 94) op = OP_CLR_DEC;
                else if (pick < 97) op = OP_CLR_BOTH;
                else op = 3'($urandom_range(5, 7));
                send_block(op, rand64(), rand64());
            end
        end
    endtask

    // Receiver stalls at random on its own pattern, independent of the sender.
    always @(posedge i_clk) begin
        if (!stall_enable) res_if.ready <= 1'b1;
        else res_if.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 7) == 0);
    end

    // Checks every result transfer against the oldest expected block.
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_blocks.size() == 0) begin
                $error("unexpected result transfer %h %h", res_if.data_out_hi,
                       res_if.data_out_lo);
                error_count++;
            end else begin
                want = expected_blocks.pop_front();
                if (res_if.data_out_hi !== want[127:64]) begin
                    $error("data_out_hi expected %h actual %h", want[127:64],
                           res_if.data_out_hi);
                    error_count++;
                end
                if (res_if.data_out_lo !== want[63:0]) begin
                    $error("data_out_lo expected %h actual %h", want[63:0],
                           res_if.data_out_lo);
                    error_count++;
                end
            end
        end
    end

    initial begin
        blk_if.valid = 1'b0;
        blk_if.opcode = '0;
        blk_if.data_hi = '0;
        blk_if.data_lo = '0;
        res_if.ready = 1'b0;
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        enc_iv_hi = '0; enc_iv_lo = '0; dec_iv_hi = '0; dec_iv_lo = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        wait_idle();
        if (error_count == 0 && expected_blocks.size() == 0) begin
            $display("[sm4_cbc_block_cipher] OK");
        end else begin
            $display("[sm4_cbc_block_cipher] ERROR");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("[sm4_cbc_block_cipher] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
sv/sm4_pkg.sv
sv/sm4_in_if.sv
sv/sm4_out_if.sv
sv/sm4_front.sv
sv/sm4_back.sv
sv/sm4_cbc_block_cipher.sv
tb/testbench.sv
